// ----- design/cusum_pkg.sv -----
// Shared types, widths, register indexes and helper functions for the
// two-sided CUSUM change detector. No dependencies.
package cusum_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 32;
	localparam int SUM_BITS    = 25;
	localparam int SLACK_BITS  = 16;
	localparam int THR_BITS    = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DIR_BITS      = 2;
	// deviation is one bit wider than a sample; working sum two bits wider than a sum
	localparam int DEV_BITS  = SAMPLE_BITS + 1;
	localparam int WORK_BITS = ((SUM_BITS > DEV_BITS) ? SUM_BITS : DEV_BITS) + 2;

	localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPECTED  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLACK     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd3;

	localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_ROSE = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_FELL = 2'd2;

	localparam logic [SLACK_BITS-1:0] SLACK_RESET = 16'd1;
	localparam logic [THR_BITS-1:0]   THR_RESET   = 24'd4;

	typedef struct packed {
		logic                          enable;
		logic signed [SAMPLE_BITS-1:0] expected_level;
		logic [SLACK_BITS-1:0]         slack_level;
		logic [THR_BITS-1:0]           threshold_level;
	} cfg_t;

	typedef struct packed {
		logic [DIR_BITS-1:0]   direction;
		logic [COUNT_BITS-1:0] began_ago;
		logic [SUM_BITS-1:0]   upward_sum;
		logic [SUM_BITS-1:0]   downward_sum;
	} result_t;

	function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
		count_up = (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	// Clamp a working sum to [0, SUM_MAX].
	function automatic logic [SUM_BITS-1:0] clamp_sum(input logic signed [WORK_BITS-1:0] s);
		logic signed [WORK_BITS-1:0] lim;
		lim = $signed({{(WORK_BITS-SUM_BITS){1'b0}}, SUM_MAX});
		if (s <= 0)
			clamp_sum = '0;
		else if (s > lim)
			clamp_sum = SUM_MAX;
		else
			clamp_sum = s[SUM_BITS-1:0];
	endfunction

endpackage

// ----- design/cusum_cfg.sv -----
// Configuration register file for the CUSUM detector.
// Depends on cusum_pkg; flags a state clear on every register write.
module cusum_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [cusum_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [cusum_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output cusum_pkg::cfg_t                       cfg,
	output logic                                  clear
);
	import cusum_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b0;
			cfg_q.expected_level  <= '0;
			cfg_q.slack_level     <= SLACK_RESET;
			cfg_q.threshold_level <= THR_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ENABLE:    cfg_q.enable          <= cfg_data[0];
				REG_EXPECTED:  cfg_q.expected_level  <= $signed(cfg_data[SAMPLE_BITS-1:0]);
				REG_SLACK:     cfg_q.slack_level     <= cfg_data[SLACK_BITS-1:0];
				REG_THRESHOLD: cfg_q.threshold_level <= cfg_data[THR_BITS-1:0];
			endcase
		end
	end

	assign cfg   = cfg_q;
	assign clear = cfg_wr_en;

endmodule

// ----- design/cusum_core.sv -----
// CUSUM state registers and the combinational update for one sample.
// Depends on cusum_pkg; the result is registered by the top level.
module cusum_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cusum_pkg::cfg_t                      cfg,
	input  logic                                 clear,
	input  logic                                 advance,
	input  logic signed [cusum_pkg::SAMPLE_BITS-1:0] sample_s1,
	output cusum_pkg::result_t                   result
);
	import cusum_pkg::*;

	logic [SUM_BITS-1:0]   up_sum_q, down_sum_q;
	logic [COUNT_BITS-1:0] up_run_q, down_run_q, run_count_q;

	logic signed [DEV_BITS-1:0]  dev;
	logic signed [WORK_BITS-1:0] dev_w, slack_w, up_w, down_w;
	logic                        up_pos, down_pos, rose, fell;
	logic [SUM_BITS-1:0]         up_sum_n, down_sum_n;
	logic [COUNT_BITS-1:0]       up_run_n, down_run_n, run_count_n;
	logic [DIR_BITS-1:0]         dir;

	always_comb begin
		dev     = $signed({sample_s1[SAMPLE_BITS-1], sample_s1})
		        - $signed({cfg.expected_level[SAMPLE_BITS-1], cfg.expected_level});
		dev_w   = WORK_BITS'(dev);
		slack_w = $signed({{(WORK_BITS-SLACK_BITS){1'b0}}, cfg.slack_level});
		up_w    = $signed({{(WORK_BITS-SUM_BITS){1'b0}}, up_sum_q}) + dev_w - slack_w;
		down_w  = $signed({{(WORK_BITS-SUM_BITS){1'b0}}, down_sum_q}) - dev_w - slack_w;
		up_pos   = up_w > 0;
		down_pos = down_w > 0;

		up_sum_n    = clamp_sum(up_w);
		down_sum_n  = clamp_sum(down_w);
		up_run_n    = up_pos ? count_up(up_run_q) : '0;
		down_run_n  = down_pos ? count_up(down_run_q) : '0;
		run_count_n = count_up(run_count_q);

		rose = up_sum_n >= {1'b0, cfg.threshold_level};
		fell = down_sum_n >= {1'b0, cfg.threshold_level};

		// upward wins a tie
		priority if (rose && (!fell || up_sum_n >= down_sum_n)) begin
			dir         = DIR_ROSE;
			run_count_n = up_run_n;
		end else if (fell) begin
			dir         = DIR_FELL;
			run_count_n = down_run_n;
		end else begin
			dir = DIR_NONE;
		end

		// alarm restarts both sides
		if (dir != DIR_NONE) begin
			up_sum_n   = '0;
			down_sum_n = '0;
			up_run_n   = '0;
			down_run_n = '0;
		end

		if (cfg.enable) begin
			result.direction    = dir;
			result.began_ago    = run_count_n;
			result.upward_sum   = up_sum_n;
			result.downward_sum = down_sum_n;
		end else begin
			// disabled: report the held state
			result.direction    = DIR_NONE;
			result.began_ago    = run_count_q;
			result.upward_sum   = up_sum_q;
			result.downward_sum = down_sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_sum_q    <= '0;
			down_sum_q  <= '0;
			up_run_q    <= '0;
			down_run_q  <= '0;
			run_count_q <= '0;
		end else if (clear) begin
			up_sum_q    <= '0;
			down_sum_q  <= '0;
			up_run_q    <= '0;
			down_run_q  <= '0;
			run_count_q <= '0;
		end else if (advance && cfg.enable) begin
			up_sum_q    <= up_sum_n;
			down_sum_q  <= down_sum_n;
			up_run_q    <= up_run_n;
			down_run_q  <= down_run_n;
			run_count_q <= run_count_n;
		end
	end

endmodule

// ----- design/two_sided_cusum_change_detector_top.sv -----
// Two-sided CUSUM change detector, top level.
// An accepted word waits in the input register; its result then goes into the
// result register. Throughput: one word per cycle while the output takes words;
// the input register feeds the sum update and holds while the output stalls.
// Reset (arst_n low, asynchronous): sums and counters cleared, enable 0,
// expected 0, slack 1, threshold 4. Depends on cusum_pkg, cusum_cfg, cusum_core.
module two_sided_cusum_change_detector_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [cusum_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [cusum_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [cusum_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [cusum_pkg::DIR_BITS-1:0]         direction,
	output logic [cusum_pkg::COUNT_BITS-1:0]       began_ago,
	output logic [cusum_pkg::SUM_BITS-1:0]         upward_sum,
	output logic [cusum_pkg::SUM_BITS-1:0]         downward_sum
);
	import cusum_pkg::*;

	cfg_t    cfg;
	logic    clear;
	result_t result;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          out_valid_q;
	result_t                       result_q;
	logic                          advance;

	// move the held word into the result register when it has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	cusum_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.clear     (clear)
	);

	cusum_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clear     (clear),
		.advance   (advance),
		.sample_s1 (sample_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign direction    = result_q.direction;
	assign began_ago    = result_q.began_ago;
	assign upward_sum   = result_q.upward_sum;
	assign downward_sum = result_q.downward_sum;

endmodule
